FILE: rtl/bdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_pkg: shared types and constants of the button debounce block
// Phase and event codes, configuration register indexes, and the structs
// passed between the core and its step logic.
// ----------------------------------------------------------------------------
package bdm_pkg;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 8;
  localparam int EVENT_W    = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] MULTICLICK_RESET = 16'd500;

  typedef enum logic [2:0] {
    PH_RELEASED    = 3'd0,
    PH_DEB_PRESS   = 3'd1,
    PH_PRESSED     = 3'd2,
    PH_DEB_RELEASE = 3'd3,
    PH_LONG        = 3'd4
  } phase_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_RELEASED = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_LONG     = 2'd2,
    EV_MULTI    = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_MULTICLICK = 2'd1
  } cfg_idx_e;

  // Control part of the button state; the timestamps travel separately
  // because their width follows the core's parameter.
  typedef struct packed {
    phase_e             phase;
    logic               prev_level;
    logic [COUNT_W-1:0] count;
  } state_t;

  typedef struct packed {
    logic               valid;
    event_e             code;
    logic [COUNT_W-1:0] count;
    logic               active;
  } result_t;

endpackage

FILE: rtl/bdm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_if: handshake channels of the button debounce block
// Tick input channel, event output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface bdm_in_if #(
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_ms;
  logic                 pin_level;

  modport source (output valid, now_ms, pin_level, input ready);
  modport sink   (input valid, now_ms, pin_level, output ready);
endinterface

interface bdm_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdm_pkg::EVENT_W-1:0]   event_code;
  logic [bdm_pkg::COUNT_W-1:0]   press_count;
  logic                          active_level;

  modport source (output valid, event_code, press_count, active_level, input ready);
  modport sink   (input valid, event_code, press_count, active_level, output ready);
endinterface

interface bdm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bdm_pkg::CFG_IDX_W-1:0] index;
  logic [bdm_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/button_debounce_multiclick_core.sv
`timescale 1ns / 1ps
// A tick beat accepted into the input register yields its event beat from the
// output register. Throughput: one tick beat per cycle unless the event sink
// stalls; input register, state update and output register form a two-stage pipeline.
// Reset: asynchronous and active low; the button starts released with the last
// pin level high, press count zero, debounce time 50 ms and window 500 ms.
// ----------------------------------------------------------------------------
// button_debounce_multiclick_core: debounced button with multiclick events
// Turns timestamped raw pin samples of an active-low button into pressed,
// released, long press and multiclick-finished events.
// ----------------------------------------------------------------------------
module button_debounce_multiclick_core #(
  parameter int TIME_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bdm_in_if.sink       in_i,
  bdm_out_if.source    out_o,
  bdm_cfg_if.sink      cfg_i
);

  // Configuration registers. Writes must arrive only while the block is idle;
  // the block does not enforce this, and takes them on every cycle without interlock.
  logic [bdm_pkg::CFG_W-1:0] debounce_q, debounce_d;
  logic [bdm_pkg::CFG_W-1:0] window_q, window_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    debounce_d = debounce_q;
    window_d   = window_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bdm_pkg::CFG_DEBOUNCE:   debounce_d = cfg_i.data;
        bdm_pkg::CFG_MULTICLICK: window_d   = cfg_i.data;
        default: begin
          // Writes to unknown register indexes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= bdm_pkg::DEBOUNCE_RESET;
      window_q   <= bdm_pkg::MULTICLICK_RESET;
    end else begin
      debounce_q <= debounce_d;
      window_q   <= window_d;
    end
  end

  // Input stage. A tick beat sits here until the output register is empty
  // or being drained, whether or not the tick produces an event. The stage
  // accepts a new beat in the same cycle it drains.
  logic                 in_valid_q, in_valid_d;
  logic [TIME_BITS-1:0] in_now_q;
  logic                 in_level_q;
  logic                 advance;
  logic                 in_take;

  logic                 out_valid_q, out_valid_d;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;
  assign in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_now_q   <= in_i.now_ms;
      in_level_q <= in_i.pin_level;
    end
  end

  // Button state. It only moves when a tick leaves the input stage, so a
  // stalled event never lets the state run ahead of what was delivered.
  bdm_pkg::state_t      state_q, state_d;
  logic [TIME_BITS-1:0] deb_start_q, deb_start_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  bdm_pkg::result_t     result;

  bdm_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .state_i         (state_q),
    .deb_start_i     (deb_start_q),
    .press_start_i   (press_start_q),
    .now_i           (in_now_q),
    .level_i         (in_level_q),
    .debounce_time_i (debounce_q),
    .window_i        (window_q),
    .state_o         (state_d),
    .deb_start_o     (deb_start_d),
    .press_start_o   (press_start_d),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= '{phase: bdm_pkg::PH_RELEASED, prev_level: 1'b1, count: '0};
      deb_start_q   <= '0;
      press_start_q <= '0;
    end else if (advance) begin
      state_q       <= state_d;
      deb_start_q   <= deb_start_d;
      press_start_q <= press_start_d;
    end
  end

  // Output register. It holds one event beat until the sink takes it.
  logic                 out_load;
  bdm_pkg::event_e      out_code_q;
  logic [bdm_pkg::COUNT_W-1:0] out_count_q;
  logic                 out_active_q;

  assign out_load    = advance && result.valid;
  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_code_q   <= result.code;
      out_count_q  <= result.count;
      out_active_q <= result.active;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_code   = out_code_q;
  assign out_o.press_count  = out_count_q;
  assign out_o.active_level = out_active_q;

endmodule

FILE: rtl/bdm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_step: one-tick update of the button state machine
// Edge detection, wrapping timer compares, next state and the event result.
// ----------------------------------------------------------------------------
module bdm_step #(
  parameter int TIME_BITS = 32
) (
  input  bdm_pkg::state_t              state_i,
  input  logic [TIME_BITS-1:0]         deb_start_i,
  input  logic [TIME_BITS-1:0]         press_start_i,
  input  logic [TIME_BITS-1:0]         now_i,
  input  logic                         level_i,
  input  logic [bdm_pkg::CFG_W-1:0]    debounce_time_i,
  input  logic [bdm_pkg::CFG_W-1:0]    window_i,
  output bdm_pkg::state_t              state_o,
  output logic [TIME_BITS-1:0]         deb_start_o,
  output logic [TIME_BITS-1:0]         press_start_o,
  output bdm_pkg::result_t             result_o
);

  logic                          sample;
  logic                          press_edge;
  logic                          release_edge;
  logic [TIME_BITS-1:0]          deb_elapsed;
  logic [TIME_BITS-1:0]          press_elapsed;
  logic                          deb_done;
  logic                          window_over;
  logic [bdm_pkg::COUNT_W-1:0]   count_inc;

  // The pin is ignored while a debounce interval runs.
  assign sample = (state_i.phase != bdm_pkg::PH_DEB_PRESS) &&
                  (state_i.phase != bdm_pkg::PH_DEB_RELEASE);
  assign press_edge   = sample && state_i.prev_level && !level_i;
  assign release_edge = sample && !state_i.prev_level && level_i;

  assign deb_elapsed   = now_i - deb_start_i;
  assign press_elapsed = now_i - press_start_i;
  assign deb_done      = deb_elapsed >= TIME_BITS'(debounce_time_i);
  assign window_over   = press_elapsed > TIME_BITS'(window_i);
  assign count_inc     = (&state_i.count) ? state_i.count
                                          : state_i.count + bdm_pkg::COUNT_W'(1);

  always_comb begin
    state_o            = state_i;
    state_o.prev_level = sample ? level_i : state_i.prev_level;
    deb_start_o        = deb_start_i;
    press_start_o      = press_start_i;
    result_o           = '{valid: 1'b0, code: bdm_pkg::EV_RELEASED,
                           count: '0, active: 1'b0};

    unique case (state_i.phase)
      bdm_pkg::PH_DEB_RELEASE: begin
        if (deb_done) begin
          state_o.phase = bdm_pkg::PH_RELEASED;
          result_o = '{valid: 1'b1, code: bdm_pkg::EV_RELEASED,
                       count: '0, active: 1'b0};
        end
      end
      bdm_pkg::PH_RELEASED: begin
        if ((state_i.count != '0) && window_over) begin
          result_o = '{valid: 1'b1, code: bdm_pkg::EV_MULTI,
                       count: state_i.count, active: 1'b0};
          state_o.count = '0;
        end
        if (press_edge) begin
          state_o.phase = bdm_pkg::PH_DEB_PRESS;
          deb_start_o   = now_i;
        end
      end
      bdm_pkg::PH_DEB_PRESS: begin
        if (deb_done) begin
          state_o.phase = bdm_pkg::PH_PRESSED;
          state_o.count = count_inc;
          press_start_o = now_i;
          result_o = '{valid: 1'b1, code: bdm_pkg::EV_PRESSED,
                       count: count_inc, active: 1'b1};
        end
      end
      bdm_pkg::PH_PRESSED: begin
        if (window_over) begin
          state_o.phase = bdm_pkg::PH_LONG;
          state_o.count = '0;
          result_o = '{valid: 1'b1, code: bdm_pkg::EV_LONG,
                       count: '0, active: 1'b1};
        end else if (release_edge) begin
          state_o.phase = bdm_pkg::PH_DEB_RELEASE;
          deb_start_o   = now_i;
        end
      end
      bdm_pkg::PH_LONG: begin
        if (release_edge) begin
          state_o.phase = bdm_pkg::PH_DEB_RELEASE;
          deb_start_o   = now_i;
        end
      end
      default: begin
        // Unreachable phase codes hold still and report nothing.
      end
    endcase
  end

endmodule

FILE: tb/button_debounce_multiclick_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_multiclick_core_test: self-checking bench of the button core
// Drives timestamped pin samples into the core and compares every event beat
// with a behavioral copy of the button state machine kept in this bench.
// A short scripted sequence runs under reset settings. Randomized click
// traffic then runs under several debounce and window settings, and a
// burst of quick clicks builds one large multiclick group.
// ----------------------------------------------------------------------------
module button_debounce_multiclick_core_test;

  localparam int TIME_BITS = 32;
  localparam int CFG_W     = bdm_pkg::CFG_W;
  localparam int CFG_IDX_W = bdm_pkg::CFG_IDX_W;
  localparam int COUNT_W   = bdm_pkg::COUNT_W;
  // Cycles with no beat accepted on any channel, for this long in a row,
  // mean the core has hung.
  localparam int HANG_LIMIT = 2000;
  // Cycles waited after the last expected event before touching the
  // registers or ending the run. The core has two register stages.
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 75;
  localparam int STORM_CLICKS = 40;

  // The index field is two bits wide, but only two registers exist.
  // Writes to the other two indexes must leave the settings alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [CFG_W-1:0] CFG_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    bdm_pkg::event_e    code;
    logic [COUNT_W-1:0] count;
    logic               active;
  } button_event_t;

  // How a scripted tick is checked: against the bench's own state machine,
  // as a tick that must not produce an event, or against a typed-in event.
  typedef enum logic [1:0] {
    BY_MODEL,
    NO_EVENT,
    TYPED_EVENT
  } check_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] now;
    logic                 pin;
    check_e               how;
    button_event_t        ev;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bdm_in_if #(.TIME_BITS(TIME_BITS)) in_if ();
  bdm_out_if                         out_if ();
  bdm_cfg_if                         cfg_if ();

  button_debounce_multiclick_core #(
    .TIME_BITS(TIME_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Button state as the bench sees it. Updated at each accepted tick or
  // register beat, never from the core's internals.
  // --------------------------------------------------------------------------
  bdm_pkg::phase_e      btn_phase;
  logic                 last_pin;
  logic [TIME_BITS-1:0] bounce_t0;
  logic [TIME_BITS-1:0] press_t0;
  logic [COUNT_W-1:0]   clicks;
  logic [CFG_W-1:0]     debounce_ms;
  logic [CFG_W-1:0]     window_ms;

  button_event_t pending_events[$];
  int unsigned   mismatches = 0;

  // Stimulus-side state.
  logic [TIME_BITS-1:0] clock_ms;
  logic                 held_level;
  int                   burst_left = 0;
  bit                   no_idle = 1'b0;

  // Advances the button state by one tick. Returns 1 and fills ev when the
  // tick produces an event.
  function automatic bit predict_tick(input logic [TIME_BITS-1:0] now, input logic pin,
                                      output button_event_t ev);
    logic [TIME_BITS-1:0] since_bounce;
    logic [TIME_BITS-1:0] since_press;
    bit press_edge;
    bit release_edge;
    bit hit;
    since_bounce = now - bounce_t0;
    since_press  = now - press_t0;
    press_edge   = 1'b0;
    release_edge = 1'b0;
    hit          = 1'b0;
    ev           = '0;
    // The pin is ignored while a debounce interval runs, so an edge seen
    // later is always relative to the last sample taken outside debounce.
    if (btn_phase != bdm_pkg::PH_DEB_PRESS && btn_phase != bdm_pkg::PH_DEB_RELEASE) begin
      if (pin != last_pin) begin
        release_edge = pin;
        press_edge   = !pin;
      end
      last_pin = pin;
    end
    case (btn_phase)
      bdm_pkg::PH_DEB_RELEASE: begin
        if (since_bounce >= TIME_BITS'(debounce_ms)) begin
          btn_phase = bdm_pkg::PH_RELEASED;
          ev  = '{bdm_pkg::EV_RELEASED, '0, 1'b0};
          hit = 1'b1;
        end
      end
      bdm_pkg::PH_RELEASED: begin
        // An expired group is closed first; a press edge in the same tick
        // still opens a new debounce.
        if (clicks != '0 && since_press > TIME_BITS'(window_ms)) begin
          ev     = '{bdm_pkg::EV_MULTI, clicks, 1'b0};
          hit    = 1'b1;
          clicks = '0;
        end
        if (press_edge) begin
          btn_phase = bdm_pkg::PH_DEB_PRESS;
          bounce_t0 = now;
        end
      end
      bdm_pkg::PH_DEB_PRESS: begin
        if (since_bounce >= TIME_BITS'(debounce_ms)) begin
          btn_phase = bdm_pkg::PH_PRESSED;
          press_t0  = now;
          if (clicks != COUNT_MAX) clicks = clicks + COUNT_W'(1);
          ev  = '{bdm_pkg::EV_PRESSED, clicks, 1'b1};
          hit = 1'b1;
        end
      end
      bdm_pkg::PH_PRESSED: begin
        // A long press swallows a release edge seen in the same tick.
        if (since_press > TIME_BITS'(window_ms)) begin
          btn_phase = bdm_pkg::PH_LONG;
          ev     = '{bdm_pkg::EV_LONG, '0, 1'b1};
          hit    = 1'b1;
          clicks = '0;
        end else if (release_edge) begin
          btn_phase = bdm_pkg::PH_DEB_RELEASE;
          bounce_t0 = now;
        end
      end
      bdm_pkg::PH_LONG: begin
        if (release_edge) begin
          btn_phase = bdm_pkg::PH_DEB_RELEASE;
          bounce_t0 = now;
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Appends one expected event behind those already waiting.
  task automatic expect_event(input button_event_t ev);
    pending_events.insert(pending_events.size(), ev);
  endtask

  // --------------------------------------------------------------------------
  // Tick sender. Beats come in bursts of random length separated by random
  // gaps, except in phases that run with no idling. Valid stays high across
  // back-to-back beats. The expectation is queued at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [TIME_BITS-1:0] now, input logic pin,
                           input check_e how, input button_event_t typed);
    int gap;
    button_event_t ev;
    bit hit;
    if (burst_left == 0) begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.now_ms    <= now;
    in_if.pin_level <= pin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // The state machine always advances so that later rows stay in step,
    // even when the row carries its own expectation.
    hit = predict_tick(now, pin, ev);
    case (how)
      BY_MODEL:    if (hit) expect_event(ev);
      TYPED_EVENT: expect_event(typed);
      default:     ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      bdm_pkg::CFG_DEBOUNCE:   debounce_ms = data;
      bdm_pkg::CFG_MULTICLICK: window_ms = data;
      default:        ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Stops sending, lets every expected event arrive, then waits out the
  // pipeline in case the last ticks were still in flight without an event.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One randomized tick. Time mostly advances by small steps or by amounts
  // near the debounce time and the window, so that intervals end right at
  // their limits. The intended button level toggles now and then, and some
  // samples bounce against it.
  task automatic random_tick();
    logic [TIME_BITS-1:0] dt;
    int pick;
    logic pin;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      dt = $urandom_range(0, 3);
    end else if (pick < 12) begin
      dt = TIME_BITS'(debounce_ms) + TIME_BITS'($urandom_range(0, 2)) - TIME_BITS'(1);
    end else if (pick < 16) begin
      dt = TIME_BITS'(window_ms) + TIME_BITS'($urandom_range(0, 2)) - TIME_BITS'(1);
    end else if (pick < 19) begin
      dt = $urandom_range(0, int'(debounce_ms) + int'(window_ms) + 2);
    end else begin
      dt = $urandom();
    end
    clock_ms = clock_ms + dt;
    if ($urandom_range(0, 3) == 0) held_level = !held_level;
    pin = ($urandom_range(0, 7) == 0) ? !held_level : held_level;
    send_tick(clock_ms, pin, BY_MODEL, '0);
  endtask

  // --------------------------------------------------------------------------
  // Scripted sequence under reset settings (50 ms debounce, 500 ms window).
  // It walks a double click that closes as a multiclick one millisecond past
  // the window, a long press across the timestamp wrap that eats a release
  // edge, a press edge ignored while long held, and a group closed in the
  // same tick as the next press edge.
  // --------------------------------------------------------------------------
  script_row_t script[25] = '{
    '{32'h0000_0000, 1'b1, NO_EVENT,    '{bdm_pkg::EV_RELEASED, 8'd0, 1'b0}},
    '{32'h0000_000A, 1'b0, BY_MODEL,    '0},
    '{32'h0000_001E, 1'b1, BY_MODEL,    '0},  // bounce inside debounce
    '{32'h0000_003C, 1'b1, TYPED_EVENT, '{bdm_pkg::EV_PRESSED,  8'd1, 1'b1}},
    '{32'h0000_0064, 1'b1, BY_MODEL,    '0},
    '{32'h0000_0096, 1'b0, TYPED_EVENT, '{bdm_pkg::EV_RELEASED, 8'd0, 1'b0}},
    '{32'h0000_00C8, 1'b0, BY_MODEL,    '0},
    '{32'h0000_00FA, 1'b0, TYPED_EVENT, '{bdm_pkg::EV_PRESSED,  8'd2, 1'b1}},
    '{32'h0000_0104, 1'b1, BY_MODEL,    '0},
    '{32'h0000_0136, 1'b1, TYPED_EVENT, '{bdm_pkg::EV_RELEASED, 8'd0, 1'b0}},
    '{32'h0000_02EE, 1'b1, NO_EVENT,    '0},  // exactly at the window
    '{32'h0000_02EF, 1'b1, TYPED_EVENT, '{bdm_pkg::EV_MULTI,    8'd2, 1'b0}},
    '{32'hFFFF_FE00, 1'b0, BY_MODEL,    '0},
    '{32'hFFFF_FE32, 1'b0, TYPED_EVENT, '{bdm_pkg::EV_PRESSED,  8'd1, 1'b1}},
    '{32'h0000_0027, 1'b1, TYPED_EVENT, '{bdm_pkg::EV_LONG,     8'd0, 1'b1}},
    '{32'hFFFF_FFFF, 1'b1, NO_EVENT,    '0},
    '{32'h0000_0030, 1'b0, NO_EVENT,    '0},
    '{32'h0000_0031, 1'b1, BY_MODEL,    '0},
    '{32'h0000_0063, 1'b1, TYPED_EVENT, '{bdm_pkg::EV_RELEASED, 8'd0, 1'b0}},
    '{32'h0000_0100, 1'b0, BY_MODEL,    '0},
    '{32'h0000_0132, 1'b0, TYPED_EVENT, '{bdm_pkg::EV_PRESSED,  8'd1, 1'b1}},
    '{32'h0000_0140, 1'b1, BY_MODEL,    '0},
    '{32'h0000_0172, 1'b1, TYPED_EVENT, '{bdm_pkg::EV_RELEASED, 8'd0, 1'b0}},
    '{32'h0000_0327, 1'b0, TYPED_EVENT, '{bdm_pkg::EV_MULTI,    8'd1, 1'b0}},
    '{32'h0000_0359, 1'b0, TYPED_EVENT, '{bdm_pkg::EV_PRESSED,  8'd1, 1'b1}}
  };

  initial begin
    logic [CFG_W-1:0] deb;
    logic [CFG_W-1:0] win;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.now_ms    = '0;
    in_if.pin_level = 1'b1;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = bdm_pkg::CFG_DEBOUNCE;
    cfg_if.data     = '0;
    btn_phase   = bdm_pkg::PH_RELEASED;
    last_pin    = 1'b1;
    bounce_t0   = '0;
    press_t0    = '0;
    clicks      = '0;
    debounce_ms = bdm_pkg::DEBOUNCE_RESET;
    window_ms   = bdm_pkg::MULTICLICK_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) send_tick(script[i].now, script[i].pin, script[i].how, script[i].ev);
    drain();

    // Random traffic. The first phases pin both settings to their extremes
    // in every combination; the rest use random settings, one of them over
    // the full range. Every phase also writes an index with no register.
    clock_ms   = $urandom();
    held_level = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin deb = '0;      win = '0;      end
        1: begin deb = CFG_MAX; win = CFG_MAX; end
        2: begin deb = '0;      win = CFG_MAX; end
        3: begin deb = CFG_MAX; win = '0;      end
        4: begin deb = CFG_W'($urandom()); win = CFG_W'($urandom()); end
        default: begin
          deb = CFG_W'($urandom_range(0, 80));
          win = CFG_W'($urandom_range(0, 700));
        end
      endcase
      write_reg(bdm_pkg::CFG_DEBOUNCE, deb);
      write_reg(bdm_pkg::CFG_MULTICLICK, win);
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom()));
      no_idle = (p % 3 == 2);
      repeat (TICKS_PER_PHASE) random_tick();
      drain();
    end

    // Click burst: with no debounce and the widest window, many quick clicks
    // land in one group, then a long quiet spell closes it.
    write_reg(bdm_pkg::CFG_DEBOUNCE, '0);
    write_reg(bdm_pkg::CFG_MULTICLICK, CFG_MAX);
    no_idle = 1'b0;
    repeat (STORM_CLICKS) begin
      clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 2));
      send_tick(clock_ms, 1'b0, BY_MODEL, '0);
      clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 2));
      send_tick(clock_ms, 1'b0, BY_MODEL, '0);
      clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 2));
      send_tick(clock_ms, 1'b1, BY_MODEL, '0);
      clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 2));
      send_tick(clock_ms, 1'b1, BY_MODEL, '0);
    end
    clock_ms = clock_ms + TIME_BITS'(70000);
    send_tick(clock_ms, 1'b1, BY_MODEL, '0);
    drain();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Event receiver. Ready follows a 16-bit mask, slot by slot, and the mask is
  // redrawn each time the mask age counter wraps; a quarter of the masks never stall,
  // and every mask has at least one ready slot so a stall never outlasts the mask.
  // --------------------------------------------------------------------------
  logic [15:0] ready_mask = 16'hFFFF;
  logic [3:0]  ready_slot = '0;
  logic [5:0]  mask_age = '0;

  always @(negedge clk_i) begin
    ready_slot   <= ready_slot + 1'b1;
    mask_age     <= mask_age + 1'b1;
    out_if.ready <= ready_mask[ready_slot];
    if (mask_age == '0) begin
      ready_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    end
  end

  // Every accepted event beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    button_event_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("event beat code %0d count %0d with nothing pending",
                                  out_if.event_code, out_if.press_count));
      end else begin
        want = pending_events.pop_front();
        if (out_if.event_code !== want.code)
          report_mismatch($sformatf("event_code got %0d expected %0d",
                                    out_if.event_code, want.code));
        if (out_if.press_count !== want.count)
          report_mismatch($sformatf("press_count got %0d expected %0d",
                                    out_if.press_count, want.count));
        if (out_if.active_level !== want.active)
          report_mismatch($sformatf("active_level got %0d expected %0d",
                                    out_if.active_level, want.active));
      end
    end
  end

  // Hang detection: counts cycles in which no channel moves a beat.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == HANG_LIMIT) begin
        $display("TIMEOUT @%0t: no beat for %0d cycles", $time, HANG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
